/* rtl/assert_macros.svh */
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define RSB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define RSB_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/rsb_pkg.sv */
package rsb_pkg;

  localparam int DATA_W      = 8;
  localparam int OUT_ADDR_W  = 32;
  localparam int OUT_TDATA_W = 40;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int COL_W       = 9;
  localparam int BL_W        = 10;
  localparam int OFF_W       = 12;

  localparam logic [CFG_IDX_W-1:0] REG_DEST_BASE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_PITCH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIX = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_LEFT   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_TOP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_WIDTH  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SPRITE_HEIGHT = 3'd6;

  localparam logic [15:0] PITCH_RST = 16'd256;
  localparam logic [2:0]  BPP_RST   = 3'd1;
  localparam logic [7:0]  HEIGHT_RST = 8'd1;

  typedef struct packed {
    logic [31:0] dest_base;
    logic [15:0] dest_pitch;
    logic [2:0]  bytes_per_pixel;
    logic [7:0]  sprite_left;
    logic [7:0]  sprite_top;
    logic [7:0]  sprite_width;
    logic [7:0]  sprite_height;
  } rsb_cfg_t;

  typedef struct packed {
    logic                  finished;
    logic [DATA_W-1:0]     write_byte;
    logic [OUT_ADDR_W-1:0] write_address;
  } rsb_res_t;

endpackage

/* rtl/rsb_cfg_regs.sv */
module rsb_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [rsb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rsb_pkg::CFG_DATA_W-1:0] cfg_data,
  output rsb_pkg::rsb_cfg_t              cfg
);
  import rsb_pkg::*;

  rsb_cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.dest_base       <= '0;
      cfg_r.dest_pitch      <= PITCH_RST;
      cfg_r.bytes_per_pixel <= BPP_RST;
      cfg_r.sprite_left     <= '0;
      cfg_r.sprite_top      <= '0;
      cfg_r.sprite_width    <= '0;
      cfg_r.sprite_height   <= HEIGHT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_DEST_BASE:     cfg_r.dest_base       <= cfg_data;
        REG_DEST_PITCH:    cfg_r.dest_pitch      <= cfg_data[15:0];
        REG_BYTES_PER_PIX: cfg_r.bytes_per_pixel <= cfg_data[2:0];
        REG_SPRITE_LEFT:   cfg_r.sprite_left     <= cfg_data[7:0];
        REG_SPRITE_TOP:    cfg_r.sprite_top      <= cfg_data[7:0];
        REG_SPRITE_WIDTH:  cfg_r.sprite_width    <= cfg_data[7:0];
        REG_SPRITE_HEIGHT: cfg_r.sprite_height   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

/* rtl/rsb_core.sv */
module rsb_core #(
  parameter int ADDR_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       take,
  input  logic [rsb_pkg::DATA_W-1:0] rle_byte,
  input  rsb_pkg::rsb_cfg_t          cfg,
  output logic                       res_valid,
  output rsb_pkg::rsb_res_t          res
);
  import rsb_pkg::*;

  localparam logic [1:0] PH_START  = 2'd0;
  localparam logic [1:0] PH_SKIP   = 2'd1;
  localparam logic [1:0] PH_COUNT  = 2'd2;
  localparam logic [1:0] PH_PIXELS = 2'd3;

  logic [1:0]            phase_r, phase_nxt;
  logic [7:0]            held_skip_r, held_skip_nxt;
  logic [BL_W-1:0]       bytes_left_r, bytes_left_nxt;
  logic [COL_W-1:0]      column_r, column_nxt;
  logic [7:0]            rows_left_r, rows_left_nxt;
  logic [ADDR_WIDTH-1:0] row_address_r, row_address_nxt;
  logic [ADDR_WIDTH-1:0] write_pointer_r, write_pointer_nxt;
  logic [15:0]           lat_pitch_r, lat_pitch_nxt;
  logic [2:0]            lat_bpp_r, lat_bpp_nxt;
  logic [7:0]            lat_width_r, lat_width_nxt;

  logic [2:0]            bpp_c;
  logic [23:0]           top_off;
  logic [10:0]           left_off;
  logic [ADDR_WIDTH-1:0] start_addr;
  logic [COL_W-1:0]      col_sk;
  logic [OFF_W-1:0]      pix_off;
  logic [ADDR_WIDTH-1:0] row_step;
  logic [7:0]            rows_dec;
  logic [BL_W-1:0]       bl_dec;
  logic [COL_W-1:0]      width_col;

  assign bpp_c      = (cfg.bytes_per_pixel == 3'd0) ? 3'd1 :
                      ((cfg.bytes_per_pixel > 3'd4) ? 3'd4 : cfg.bytes_per_pixel);
  assign top_off    = 24'(cfg.sprite_top) * 24'(cfg.dest_pitch);
  assign left_off   = 11'(cfg.sprite_left) * 11'(bpp_c);
  assign start_addr = ADDR_WIDTH'(cfg.dest_base) + ADDR_WIDTH'(top_off)
                      + ADDR_WIDTH'(left_off);
  assign col_sk     = column_r + COL_W'(held_skip_r);
  assign pix_off    = OFF_W'(col_sk) * OFF_W'(lat_bpp_r);
  assign row_step   = row_address_r + ADDR_WIDTH'(lat_pitch_r);
  assign rows_dec   = rows_left_r - 8'd1;
  assign bl_dec     = bytes_left_r - BL_W'(1);
  assign width_col  = COL_W'(lat_width_r);

  always_comb begin
    phase_nxt         = phase_r;
    held_skip_nxt     = held_skip_r;
    bytes_left_nxt    = bytes_left_r;
    column_nxt        = column_r;
    rows_left_nxt     = rows_left_r;
    row_address_nxt   = row_address_r;
    write_pointer_nxt = write_pointer_r;
    lat_pitch_nxt     = lat_pitch_r;
    lat_bpp_nxt       = lat_bpp_r;
    lat_width_nxt     = lat_width_r;
    res_valid         = 1'b0;
    res               = '0;
    unique case (phase_r)
      PH_START: begin
        lat_bpp_nxt     = bpp_c;
        lat_pitch_nxt   = cfg.dest_pitch;
        lat_width_nxt   = cfg.sprite_width;
        rows_left_nxt   = (cfg.sprite_height == 8'd0) ? 8'd1 : cfg.sprite_height;
        row_address_nxt = start_addr;
        column_nxt      = '0;
        held_skip_nxt   = rle_byte;
        phase_nxt       = PH_COUNT;
      end
      PH_SKIP: begin
        if (rows_left_r == 8'd0) begin
          res_valid    = 1'b1;
          res.finished = 1'b1;
          phase_nxt    = PH_START;
        end else begin
          held_skip_nxt = rle_byte;
          phase_nxt     = PH_COUNT;
        end
      end
      PH_COUNT: begin
        column_nxt = col_sk;
        if (rle_byte != '0) begin
          bytes_left_nxt    = BL_W'(rle_byte) * BL_W'(lat_bpp_r);
          write_pointer_nxt = row_address_r + ADDR_WIDTH'(pix_off);
          column_nxt        = col_sk + COL_W'(rle_byte);
          phase_nxt         = PH_PIXELS;
        end else if (col_sk == '0) begin
          res_valid    = 1'b1;
          res.finished = 1'b1;
          phase_nxt    = PH_START;
        end else if (col_sk == width_col) begin
          rows_left_nxt = rows_dec;
          if (rows_dec == 8'd0) begin
            res_valid    = 1'b1;
            res.finished = 1'b1;
            phase_nxt    = PH_START;
          end else begin
            column_nxt      = '0;
            row_address_nxt = row_step;
            phase_nxt       = PH_SKIP;
          end
        end else begin
          phase_nxt = PH_SKIP;
        end
      end
      PH_PIXELS: begin
        res_valid         = 1'b1;
        res.write_address = OUT_ADDR_W'(write_pointer_r);
        res.write_byte    = rle_byte;
        write_pointer_nxt = write_pointer_r + ADDR_WIDTH'(1);
        bytes_left_nxt    = bl_dec;
        if (bl_dec == '0) begin
          phase_nxt = PH_SKIP;
          if (column_r == width_col) begin
            rows_left_nxt = rows_dec;
            if (rows_dec != 8'd0) begin
              column_nxt      = '0;
              row_address_nxt = row_step;
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r         <= PH_START;
      held_skip_r     <= '0;
      bytes_left_r    <= '0;
      column_r        <= '0;
      rows_left_r     <= '0;
      row_address_r   <= '0;
      write_pointer_r <= '0;
      lat_pitch_r     <= PITCH_RST;
      lat_bpp_r       <= BPP_RST;
      lat_width_r     <= '0;
    end else if (take) begin
      phase_r         <= phase_nxt;
      held_skip_r     <= held_skip_nxt;
      bytes_left_r    <= bytes_left_nxt;
      column_r        <= column_nxt;
      rows_left_r     <= rows_left_nxt;
      row_address_r   <= row_address_nxt;
      write_pointer_r <= write_pointer_nxt;
      lat_pitch_r     <= lat_pitch_nxt;
      lat_bpp_r       <= lat_bpp_nxt;
      lat_width_r     <= lat_width_nxt;
    end
  end

endmodule

/* rtl/rsb_out_reg.sv */
module rsb_out_reg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            take,
  input  logic                            res_valid,
  input  rsb_pkg::rsb_res_t               res,
  output logic                            can_take,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rsb_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                            out_tuser
);
  import rsb_pkg::*;

  logic     valid_r;
  rsb_res_t res_r;

  assign can_take   = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = {res_r.write_byte, res_r.write_address};
  assign out_tuser  = res_r.finished;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (take && res_valid) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      res_r <= res;
    end
  end

endmodule

/* rtl/rle_sprite_blitter.sv */
// Run-length transparent sprite decoder producing frame buffer byte writes.
// in_*  : one coded byte per request (skip count, opaque count, pixel bytes).
// out_* : one write per pixel byte; tuser high marks the sprite finish,
//         which carries address and byte of zero.
// cfg_* : register writes, always ready; take effect at the next sprite start,
//         as the geometry is latched by the first byte of each sprite.
// Requests are taken one per cycle while in_tready is high.
// A result shows on out_* the cycle after the request that causes it; the
// single output register is the only buffer, so in_tready drops only while
// that register holds a result and out_tready is low.
// When a pixel byte closes the last row, the finish needs one more input byte,
// whose value is ignored.
// Reset (rst_n low, synchronous) empties the output register, restores the
// register defaults and waits for the first byte of a new sprite.
module rle_sprite_blitter #(
  parameter int ADDR_WIDTH = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [rsb_pkg::DATA_W-1:0]      in_tdata,   // [7:0] rle_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [rsb_pkg::OUT_TDATA_W-1:0] out_tdata,  // [31:0] write_address, [39:32] write_byte
  output logic                            out_tuser,  // [0] finished
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rsb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rsb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import rsb_pkg::*;

  rsb_cfg_t cfg;
  rsb_res_t res;
  logic     res_valid;
  logic     can_take;
  logic     take;

  assign in_tready = can_take;
  assign take      = in_tvalid && can_take;

  rsb_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rsb_core #(.ADDR_WIDTH(ADDR_WIDTH)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .rle_byte  (in_tdata),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  rsb_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .take       (take),
    .res_valid  (res_valid),
    .res        (res),
    .can_take   (can_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

/* rtl/rsb_checker.sv */
`include "assert_macros.svh"

module rsb_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [rsb_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic                            out_tuser
);

  `RSB_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")
  `RSB_ASSERT(a_finish_clean, out_tvalid && out_tuser |-> out_tdata == '0, "finish carries address or data")
  `RSB_ASSERT(a_ready_free, !out_tvalid || out_tready |-> in_tready, "input blocked with output free")
  `RSB_ASSERT(a_result_cause, $rose(out_tvalid) |-> $past(in_tvalid && in_tready), "result without request")
  `RSB_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid, "result after reset")

endmodule

bind rle_sprite_blitter rsb_checker u_rsb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
